// File: hw/rtl/bbd_pkg.sv
package bbd_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_ZOOM  = 64;
    localparam int SUM_W         = 20;
    localparam int ZSQ_W         = 16;

    typedef enum logic [1:0] {
        CFG_BITS_CODE    = 2'd0,
        CFG_ZOOM_REQUEST = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_MOD,
        ST_DIV,
        ST_EMIT,
        ST_END
    } t_state;

    typedef struct packed {
        logic [7:0]  gray;
        logic [11:0] col;
        logic [15:0] row;
        logic [6:0]  zoom;
        logic        done;
    } t_result;

    // per-pixel increment for zooms below pixels-per-byte: p*255/(mask*z*z)
    function automatic logic [7:0] small_inc(input logic [1:0] code, input logic [2:0] zf,
                                             input logic [3:0] p);
        logic [7:0] v;
        v = 8'd0;
        unique case (code)
            2'd0: begin
                if (p[0]) begin
                    unique case (zf)
                        3'd1:    v = 8'd255;
                        3'd2:    v = 8'd63;
                        3'd3:    v = 8'd28;
                        3'd4:    v = 8'd15;
                        3'd5:    v = 8'd10;
                        3'd6:    v = 8'd7;
                        3'd7:    v = 8'd5;
                        default: v = 8'd0;
                    endcase
                end
            end
            2'd1: begin
                unique case ({zf, p[1:0]})
                    5'b001_01: v = 8'd85;
                    5'b001_10: v = 8'd170;
                    5'b001_11: v = 8'd255;
                    5'b010_01: v = 8'd21;
                    5'b010_10: v = 8'd42;
                    5'b010_11: v = 8'd63;
                    5'b011_01: v = 8'd9;
                    5'b011_10: v = 8'd18;
                    5'b011_11: v = 8'd28;
                    default:   v = 8'd0;
                endcase
            end
            default: begin
                if (zf == 3'd1) v = 8'({4'd0, p} * 8'd17);
            end
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/bbd_sum_ram.sv
module bbd_sum_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int W     = 20
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bbd_div.sv
module bbd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bbd_pkg::SUM_W-1:0] i_dividend,
    input  logic [bbd_pkg::ZSQ_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [bbd_pkg::SUM_W-1:0] o_quotient
);
    import bbd_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_quo;
    logic [ZSQ_W-1:0] r_rem;
    logic [ZSQ_W-1:0] r_div;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [ZSQ_W:0]   trial;
    logic             ge;

    // restoring division, one quotient bit a cycle
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(SUM_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? ZSQ_W'(trial - {1'b0, r_div}) : trial[ZSQ_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: hw/rtl/packed_bitmap_box_downsampler.sv
// Box-filter preview of a packed 1, 2 or 4 bit raster. One byte is taken at a time and runs
// through a read-modify-write of the column sum memory. With a zoom below pixels-per-byte each
// pixel is a memory read, then an add and write back, and each cell it completes adds an emit
// step; with a larger zoom a byte does one read-modify-write, or none when it lies outside every
// whole block, and the byte that completes a block then waits for the 20-step sequential
// divider that forms the block mean. A result that finds the output register still full waits
// there until it is taken. Any configuration write restarts the image at row 0; the sum memory
// needs no clearing after reset.
module packed_bitmap_box_downsampler #(
    parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ZOOM  = bbd_pkg::DEF_MAX_ZOOM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_packed_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_gray,
    output logic [11:0] o_out_col,
    output logic [15:0] o_out_row,
    output logic [6:0]  o_effective_zoom,
    output logic        o_last_of_item,
    output logic        o_image_done
);
    import bbd_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration
    logic [1:0]  r_bits_code;
    logic [6:0]  r_zoom_req;
    logic [12:0] r_img_w;
    logic [15:0] r_img_h;

    // derived configuration
    logic [1:0]  code;
    logic [1:0]  lg_ppb;
    logic [3:0]  ppb;
    logic [3:0]  pbits;
    logic [7:0]  scale;
    logic [8:0]  zr9;
    logic [6:0]  zr;
    logic        low_zoom;
    logic [7:0]  zf;
    logic [7:0]  nbp;
    logic [16:0] w17;
    logic [12:0] w;
    logic [15:0] h;
    logic [15:0] wbits;
    logic [12:0] bpr;
    logic [15:0] zsq;

    always_comb begin
        code   = (r_bits_code == 2'd3) ? 2'd2 : r_bits_code;
        lg_ppb = 2'd3 - code;
        ppb    = 4'd8 >> code;
        pbits  = 4'd1 << code;
        unique case (code)
            2'd0:    scale = 8'd255;
            2'd1:    scale = 8'd85;
            default: scale = 8'd17;
        endcase
        zr9 = {2'b0, r_zoom_req};
        if (zr9 == 9'd0) zr9 = 9'd1;
        if (zr9 > 9'(MAX_ZOOM)) zr9 = 9'(MAX_ZOOM);
        zr       = zr9[6:0];
        low_zoom = {1'b0, zr} < {4'd0, ppb};
        if (low_zoom) zf = {1'b0, zr};
        else          zf = ({1'b0, zr} + {5'd0, ppb[3:1]}) & ~{4'd0, ppb - 4'd1};
        nbp = zf >> lg_ppb;
        w17 = {4'd0, r_img_w};
        if (w17 == 17'd0) w17 = 17'd1;
        if (w17 > 17'(MAX_WIDTH)) w17 = 17'(MAX_WIDTH);
        w     = w17[12:0];
        h     = (r_img_h == 16'd0) ? 16'd1 : r_img_h;
        wbits = ({3'd0, w} << code) + 16'd7;
        bpr   = wbits[15:3];
        zsq   = zf * zf;
    end

    // control and position state
    t_state      r_state, n_state;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_k, n_k;
    logic [15:0] r_src_row, n_src_row;
    logic [12:0] r_byte_col, n_byte_col;
    logic [7:0]  r_band, n_band;
    logic [15:0] r_dst, n_dst;
    logic [12:0] r_x, n_x;
    logic [7:0]  r_xm, n_xm;
    logic [12:0] r_c, n_c;
    logic [7:0]  r_grp, n_grp;
    logic [12:0] r_xz, n_xz;
    logic [AW-1:0] r_addr, n_addr;
    logic        r_clear, n_clear;
    logic        r_emit, n_emit;
    logic        r_done, n_done;
    logic [10:0] r_inc, n_inc;
    t_result     r_cand, n_cand;
    t_result     r_pend, n_pend;
    logic        r_have_pend, n_have_pend;
    logic        r_o_valid;
    t_result     r_o_res;
    logic        r_o_last;

    // memory and divider
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [SUM_W-1:0] mem_wdata, mem_rdata;
    logic             div_start, div_done;
    logic [SUM_W-1:0] div_quo;

    bbd_sum_ram #(.DEPTH(MAX_WIDTH), .AW(AW), .W(SUM_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mem_wdata),
        .i_divisor  (zsq),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // pixel at the head of the shifting byte
    logic [3:0] pix;
    always_comb begin
        unique case (code)
            2'd0:    pix = {3'd0, r_byte[7]};
            2'd1:    pix = {2'd0, r_byte[7:6]};
            default: pix = r_byte[7:4];
        endcase
    end

    // scaled sum of all pixels of the byte
    logic [4:0]  psum;
    logic [12:0] lut;
    always_comb begin
        psum = '0;
        for (int i = 0; i < 8; i++) begin
            unique case (code)
                2'd0:    psum = psum + 5'(r_byte[i]);
                2'd1:    if (i < 4) psum = psum + 5'(r_byte[2*i +: 2]);
                default: if (i < 2) psum = psum + 5'(r_byte[4*i +: 4]);
            endcase
        end
        lut = psum * scale;
    end

    // block range checks for large zoom
    logic [21:0] prodx;
    logic [24:0] prody;
    logic        inx, iny, lastx, lasty;
    assign prodx = ({1'b0, r_xz} + 14'd1) * zf;
    assign prody = ({1'b0, r_dst} + 17'd1) * zf;
    assign inx   = prodx <= 22'(w);
    assign iny   = prody <= 25'(h);
    assign lastx = (prodx + 22'(zf)) > 22'(w);
    assign lasty = (prody + 25'(zf)) > 25'(h);

    logic out_free, out_load, out_last;
    t_result out_res;
    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        logic row_end;
        n_state     = r_state;
        n_byte      = r_byte;
        n_k         = r_k;
        n_src_row   = r_src_row;
        n_byte_col  = r_byte_col;
        n_band      = r_band;
        n_dst       = r_dst;
        n_x         = r_x;
        n_xm        = r_xm;
        n_c         = r_c;
        n_grp       = r_grp;
        n_xz        = r_xz;
        n_addr      = r_addr;
        n_clear     = r_clear;
        n_emit      = r_emit;
        n_done      = r_done;
        n_inc       = r_inc;
        n_cand      = r_cand;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;
        mem_wdata   = (r_clear ? '0 : mem_rdata) + SUM_W'(r_inc);
        div_start   = 1'b0;
        out_load    = 1'b0;
        out_last    = 1'b0;
        out_res     = r_pend;
        row_end     = 1'b0;
        o_ready     = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_byte  = i_packed_byte;
                    n_k     = '0;
                    n_state = ST_PIX;
                end
            end
            ST_PIX: begin
                if (low_zoom) begin
                    if (r_k < ppb && r_x < w) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_c);
                        n_addr    = AW'(r_c);
                        n_clear   = (r_band == 8'd0) && (r_xm == 8'd0);
                        n_emit    = ((r_band == zf - 8'd1) || (r_src_row == h - 16'd1))
                                    && ((r_xm == zf - 8'd1) || (r_x == w - 13'd1));
                        n_done    = (r_src_row == h - 16'd1) && (r_x == w - 13'd1);
                        n_inc     = {3'd0, small_inc(code, zf[2:0], pix)};
                        n_state   = ST_MOD;
                    end else begin
                        n_state = ST_END;
                    end
                end else if (inx && iny) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_xz);
                    n_addr    = AW'(r_xz);
                    n_clear   = (r_band == 8'd0) && (r_grp == 8'd0);
                    n_emit    = (r_band == zf - 8'd1) && (r_grp == nbp - 8'd1);
                    n_done    = lastx && lasty;
                    n_inc     = lut[10:0];
                    n_state   = ST_MOD;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_MOD: begin
                mem_we      = 1'b1;
                n_cand.gray = mem_wdata[7:0];
                n_cand.col  = low_zoom ? r_c[11:0] : r_xz[11:0];
                n_cand.row  = r_dst;
                n_cand.zoom = zf[6:0];
                n_cand.done = r_done;
                if (low_zoom) begin
                    n_x    = r_x + 13'd1;
                    n_k    = r_k + 4'd1;
                    n_byte = r_byte << pbits;
                    if (r_xm == zf - 8'd1) begin
                        n_xm = '0;
                        n_c  = r_c + 13'd1;
                    end else begin
                        n_xm = r_xm + 8'd1;
                    end
                    n_state = r_emit ? ST_EMIT : ST_PIX;
                end else if (r_emit) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_cand.gray = div_quo[7:0];
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // a held result goes out only once a later one shows it is not the last
                if (r_have_pend) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_pend   = r_cand;
                        n_state  = low_zoom ? ST_PIX : ST_END;
                    end
                end else begin
                    n_pend      = r_cand;
                    n_have_pend = 1'b1;
                    n_state     = low_zoom ? ST_PIX : ST_END;
                end
            end
            ST_END: begin
                if (!r_have_pend || out_free) begin
                    if (r_have_pend) begin
                        out_load    = 1'b1;
                        out_last    = 1'b1;
                        n_have_pend = 1'b0;
                    end
                    n_state    = ST_IDLE;
                    n_byte_col = r_byte_col + 13'd1;
                    if (r_byte_col + 13'd1 >= bpr) begin
                        row_end    = 1'b1;
                        n_byte_col = '0;
                        n_src_row  = r_src_row + 16'd1;
                        if (r_band + 8'd1 >= zf) begin
                            n_band = '0;
                            n_dst  = r_dst + 16'd1;
                        end else begin
                            n_band = r_band + 8'd1;
                        end
                        if (r_src_row + 16'd1 >= h) begin
                            n_src_row = '0;
                            n_band    = '0;
                            n_dst     = '0;
                        end
                    end else if (!low_zoom) begin
                        if (r_grp >= nbp - 8'd1) begin
                            n_grp = '0;
                            n_xz  = r_xz + 13'd1;
                        end else begin
                            n_grp = r_grp + 8'd1;
                        end
                    end
                    if (row_end) begin
                        n_x   = '0;
                        n_xm  = '0;
                        n_c   = '0;
                        n_grp = '0;
                        n_xz  = '0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // any register write restarts the image
        if (i_cfg_we) begin
            n_byte_col = '0;
            n_src_row  = '0;
            n_band     = '0;
            n_dst      = '0;
            n_x        = '0;
            n_xm       = '0;
            n_c        = '0;
            n_grp      = '0;
            n_xz       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_pend <= 1'b0;
            r_o_valid   <= 1'b0;
            r_src_row   <= '0;
            r_byte_col  <= '0;
            r_band      <= '0;
            r_dst       <= '0;
            r_x         <= '0;
            r_xm        <= '0;
            r_c         <= '0;
            r_grp       <= '0;
            r_xz        <= '0;
            r_bits_code <= 2'd0;
            r_zoom_req  <= 7'd1;
            r_img_w     <= 13'd1;
            r_img_h     <= 16'd1;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            r_src_row   <= n_src_row;
            r_byte_col  <= n_byte_col;
            r_band      <= n_band;
            r_dst       <= n_dst;
            r_x         <= n_x;
            r_xm        <= n_xm;
            r_c         <= n_c;
            r_grp       <= n_grp;
            r_xz        <= n_xz;
            if (out_load)     r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_BITS_CODE:    r_bits_code <= i_cfg_data[1:0];
                    CFG_ZOOM_REQUEST: r_zoom_req  <= i_cfg_data[6:0];
                    CFG_IMAGE_WIDTH:  r_img_w     <= i_cfg_data[12:0];
                    CFG_IMAGE_HEIGHT: r_img_h     <= i_cfg_data;
                    default:          r_img_h     <= r_img_h;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_k     <= n_k;
        r_addr  <= n_addr;
        r_clear <= n_clear;
        r_emit  <= n_emit;
        r_done  <= n_done;
        r_inc   <= n_inc;
        r_cand  <= n_cand;
        r_pend  <= n_pend;
        if (out_load) begin
            r_o_res  <= out_res;
            r_o_last <= out_last;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_gray           = r_o_res.gray;
    assign o_out_col        = r_o_res.col;
    assign o_out_row        = r_o_res.row;
    assign o_effective_zoom = r_o_res.zoom;
    assign o_last_of_item   = r_o_last;
    assign o_image_done     = r_o_res.done;
endmodule

// File: dv/packed_bitmap_box_downsampler_test.sv
`timescale 1ns / 100ps

module packed_bitmap_box_downsampler_test;
    import bbd_pkg::*;

    localparam int MAXW = 4096;
    localparam int MAXZ = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]  gray;
        logic [11:0] col;
        logic [15:0] row;
        logic [6:0]  zoom;
        logic        last;
        logic        done;
    } t_cell;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_packed_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_gray;
    logic [11:0] o_out_col;
    logic [15:0] o_out_row;
    logic [6:0]  o_effective_zoom;
    logic        o_last_of_item;
    logic        o_image_done;

    packed_bitmap_box_downsampler DUT (.*);

    // predictor state
    logic [1:0]  m_bits_code;
    logic [6:0]  m_zoom;
    logic [12:0] m_width;
    logic [15:0] m_height;
    logic [19:0] col_sum [MAXW];
    int unsigned m_src_row, m_byte_col, m_band_row, m_dst_row;

    logic [7:0] byte_queue[$];
    t_cell      cell_queue[$];
    int         mismatches;
    int         idle_cycles;
    bit         hold_rx;
    bit         hold_tx;
    bit         timed_out;
    int         tx_gap, rx_gap;

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic restart_image();
        m_src_row = 0;
        m_byte_col = 0;
        m_band_row = 0;
        m_dst_row = 0;
    endtask

    // predicts the cells caused by one transfer of a packed byte
    task automatic predict_byte(input logic [7:0] pb);
        int unsigned code, bits, ppb, mask, scale, zr, w, h, zf, bpr;
        int unsigned x, p, c, dv, txz, tyz, nbp, xz, lut, first;
        bit low_zoom, lastband;
        t_cell cl;
        first = cell_queue.size();
        code = (m_bits_code > 2) ? 2 : m_bits_code;
        bits = 1 << code;
        ppb = 8 / bits;
        mask = (1 << bits) - 1;
        scale = 255 / mask;
        zr = m_zoom;
        w = m_width;
        h = m_height;
        if (zr < 1) zr = 1;
        if (zr > MAXZ) zr = MAXZ;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        if (h < 1) h = 1;
        bpr = (w * bits + 7) / 8;
        low_zoom = zr < ppb;
        if (low_zoom) zf = zr;
        else begin
            zf = ((zr + ppb / 2) / ppb) * ppb;
            if (zf < 1) zf = 1;
        end
        if (low_zoom) begin
            lastband = (m_band_row == zf - 1) || (m_src_row == h - 1);
            dv = mask * zf * zf;
            for (int k = 0; k < ppb; k++) begin
                x = m_byte_col * ppb + k;
                if (x >= w) break;
                p = (pb >> (8 - bits * (k + 1))) & mask;
                c = x / zf;
                if (m_band_row == 0 && x % zf == 0) col_sum[c] = '0;
                col_sum[c] = col_sum[c] + 20'((p * 255) / dv);
                if (lastband && (x % zf == zf - 1 || x == w - 1)) begin
                    cl = '{gray: col_sum[c][7:0], col: c[11:0], row: m_dst_row[15:0],
                           zoom: zf[6:0], last: 1'b0,
                           done: (m_src_row == h - 1 && x == w - 1)};
                    cell_queue.push_back(cl);
                end
            end
        end else begin
            txz = w / zf;
            tyz = h / zf;
            nbp = zf / ppb;
            if (nbp < 1) nbp = 1;
            xz = m_byte_col / nbp;
            if (xz < txz && m_dst_row < tyz) begin
                lut = 0;
                for (int k = 0; k < ppb; k++)
                    lut += ((pb >> (8 - bits * (k + 1))) & mask) * scale;
                if (m_band_row == 0 && m_byte_col % nbp == 0) col_sum[xz] = '0;
                col_sum[xz] = col_sum[xz] + 20'(lut);
                if (m_band_row == zf - 1 && m_byte_col % nbp == nbp - 1) begin
                    cl = '{gray: 8'(col_sum[xz] / (zf * zf)), col: xz[11:0],
                           row: m_dst_row[15:0], zoom: zf[6:0], last: 1'b0,
                           done: (xz == txz - 1 && m_dst_row == tyz - 1)};
                    cell_queue.push_back(cl);
                end
            end
        end
        if (cell_queue.size() > first) cell_queue[$].last = 1'b1;
        m_byte_col++;
        if (m_byte_col >= bpr) begin
            m_byte_col = 0;
            m_band_row++;
            if (m_band_row >= zf) begin
                m_band_row = 0;
                m_dst_row = (m_dst_row + 1) & 16'hFFFF;
            end
            m_src_row++;
            if (m_src_row >= h) restart_image();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (i_valid && o_ready) predict_byte(i_packed_byte);
            if (!i_valid || o_ready) begin
                if (tx_gap > 0 || hold_tx || byte_queue.size() == 0) begin
                    i_valid <= 1'b0;
                    if (tx_gap > 0) tx_gap <= tx_gap - 1;
                end else begin
                    i_valid <= 1'b1;
                    i_packed_byte <= byte_queue.pop_front();
                    tx_gap <= gap_len();
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cell want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (cell_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected cell gray=%0d col=%0d row=%0d",
                                 o_gray, o_out_col, o_out_row);
                end else begin
                    want = cell_queue.pop_front();
                    if (want.gray !== o_gray || want.col !== o_out_col ||
                        want.row !== o_out_row || want.zoom !== o_effective_zoom ||
                        want.last !== o_last_of_item || want.done !== o_image_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                                     want.gray, want.col, want.row, want.zoom, want.last,
                                     want.done, o_gray, o_out_col, o_out_row,
                                     o_effective_zoom, o_last_of_item, o_image_done);
                    end
                end
            end
            if (hold_rx) i_ready <= 1'b0;
            else if (rx_gap > 0) begin
                i_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                i_ready <= 1'b1;
                rx_gap <= gap_len();
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_rx || !i_rst_n)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (byte_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (cell_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BITS_CODE:    m_bits_code = val[1:0];
            CFG_ZOOM_REQUEST: m_zoom = val[6:0];
            CFG_IMAGE_WIDTH:  m_width = val[12:0];
            default:          m_height = val;
        endcase
        restart_image();
    endtask

    task automatic set_image(input int bc, input int zr, input int w, input int h);
        write_reg(CFG_BITS_CODE, 16'(bc));
        write_reg(CFG_ZOOM_REQUEST, 16'(zr));
        write_reg(CFG_IMAGE_WIDTH, 16'(w));
        write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    endtask

    // n times bpr_bytes random bytes at the current setting
    task automatic queue_image(input int n, input int bpr_bytes);
        for (int i = 0; i < n * bpr_bytes; i++) byte_queue.push_back(8'($urandom));
    endtask

    function automatic int row_bytes(input int bc, input int w);
        int b;
        b = 1 << ((bc > 2) ? 2 : bc);
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        return (w * b + 7) / 8;
    endfunction

    initial begin
        int bc, zr, w, h, n, nb;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_BITS_CODE;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_packed_byte = '0;
        hold_rx = 1'b0;
        hold_tx = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        m_bits_code = 2'd0;
        m_zoom = 7'd1;
        m_width = 13'd1;
        m_height = 16'd1;
        for (int i = 0; i < MAXW; i++) col_sum[i] = '0;
        restart_image();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting, then extremes and odd codes
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'h80);
        wait_drained();
        set_image(3, 0, 0, 0);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h5A);
        wait_drained();
        set_image(0, 3, 11, 4);          // small zoom, partial edges, padding pixels
        byte_queue.push_back(8'hFF); byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'hE0);
        byte_queue.push_back(8'hA5); byte_queue.push_back(8'h5A);
        byte_queue.push_back(8'hFF); byte_queue.push_back(8'h01);
        wait_drained();
        set_image(1, 127, 5000, 65535);  // zoom and width saturate
        for (int i = 0; i < 4; i++) byte_queue.push_back(8'hFF);
        wait_drained();
        set_image(2, 64, 8, 2);          // image smaller than the zoom
        for (int i = 0; i < 4; i++) byte_queue.push_back(8'hFF);
        wait_drained();
        set_image(2, 2, 4, 2);           // large zoom, bytes past the end
        for (int i = 0; i < 6; i++) byte_queue.push_back(8'($urandom));
        wait_drained();

        // long receiver hold-off while bytes keep coming
        set_image(0, 1, 16, 8);
        queue_image(1, 16);
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        wait_drained();

        // random images, mostly small
        n = 0;
        while (n < 175) begin
            bc = $urandom_range(0, 3);
            zr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 9);
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
            h = $urandom_range(0, 12);
            if (w > 64) h = 1;
            set_image(bc, zr, w, h);
            nb = row_bytes(bc, w) * ((h < 1) ? 1 : h);
            if (nb > 48) nb = 48;
            queue_image(1, nb);
            n += nb;
            if ($urandom_range(0, 3) == 0) begin
                hold_tx = 1'b1;
                while (cell_queue.size() != 0) @(posedge i_clk);
                hold_tx = 1'b0;
            end
            wait_drained();
        end

        wait_drained();
        if (mismatches == 0 && cell_queue.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_sum_ram.sv
hw/rtl/bbd_div.sv
hw/rtl/packed_bitmap_box_downsampler.sv
dv/packed_bitmap_box_downsampler_test.sv
